[sv/bcdq_pkg.sv]
package bcdq_pkg;

    // Command codes carried in the cmd field of an input transaction
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_ACCEPTED = 3'd0,
        STATUS_EVICTED  = 3'd1,
        STATUS_REJECTED = 3'd2,
        STATUS_STOPPED  = 3'd3,
        STATUS_EMPTY    = 3'd4,
        STATUS_POPPED   = 3'd5
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EVICT_NOTE,
        ST_EVICT_SUB,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DECIDE,
        ST_DROP_NEW,
        ST_POP_RD,
        ST_POP_FIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] job_bytes;
        logic        job_droppable;
        logic [15:0] job_tag;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [4:0]  evicted_count;
        logic [15:0] out_tag;
        logic [31:0] out_bytes;
        logic        out_droppable;
        logic [4:0]  jobs_held;
        logic [39:0] bytes_held;
        logic [31:0] lost_records;
        logic [47:0] lost_bytes;
        logic        overflow_seen;
    } out_item_t;

    // One queue entry as held in the store
    typedef struct packed {
        logic [15:0] tag;
        logic [31:0] bytes;
        logic        drop_ok;
    } entry_t;

    // Register index of byte_cap (taken from paddr[2])
    localparam logic        CFG_BYTE_CAP     = 1'b0;
    localparam logic [31:0] BYTE_CAP_RESET   = 32'd67108864;
    localparam logic [31:0] DROP_RECORDS_MAX = 32'hFFFF_FFFF;
    localparam logic [47:0] DROP_BYTES_MAX   = 48'hFFFF_FFFF_FFFF;

endpackage

[sv/byte_capped_drop_oldest_queue_top.sv]
// Byte-capped admission queue with drop-oldest eviction.
// Input channel (in_valid/in_stall/in_item) carries one command per transaction:
// push a job, pop the oldest job, stop further pushes, or clear drop counters.
// Output channel (out_valid/out_stall/out_item) returns exactly one result per
// command, in command order, with the queue occupancy and drop counters after it.
// The block takes one command at a time; in_stall is high while a command runs.
// Command flow: stop, clear, a stopped push and a pop on an empty queue go straight
// to the result; an oversized push is counted as lost; a pop reads the oldest job;
// other pushes run a fit check, then are admitted or rejected.
// A push that evicts scans for the oldest droppable victim, counts it as lost, takes
// its bytes off the total and moves each older entry into the victim's place; the
// scan may run out of droppable entries. The next command is taken in the cycle after
// a result loads. The sequencer uses a single 49-bit add/subtract unit and a store
// that it drives with one read or one write per state.
// A finished result waits in the output register while the next command is taken;
// if the receiver stalls, the following result holds inside the block and no
// further command is taken until the output register frees.
// Reset empties the queue, clears counters and flags, and sets byte_cap to
// 67108864; the store needs no clearing pass. byte_cap is written over APB at
// address 0; the user must write it only while the block is idle; the block has no guard for this.
module byte_capped_drop_oldest_queue_top
    import bcdq_pkg::*;
#(
    parameter int MAX_JOBS      = 16,
    parameter int BARRIER_SLACK = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = MAX_JOBS + BARRIER_SLACK;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int EW    = $clog2(MAX_JOBS + 2);

    state_t          state_reg;
    state_t          state_next;
    in_item_t        req_reg;
    logic [31:0]     byte_cap_reg;
    logic [AW-1:0]   head_reg;
    logic [CW-1:0]   count_reg;
    logic [39:0]     byte_total_reg;
    logic [31:0]     drop_rec_reg;
    logic [47:0]     drop_bytes_reg;
    logic            stop_reg;
    logic            overflow_reg;
    logic [EW-1:0]   evicted_reg;
    logic [CW-1:0]   scan_pos_reg;
    logic [CW-1:0]   shift_pos_reg;
    logic            fits_reg;
    status_t         status_reg;
    entry_t          pop_entry_reg;
    logic            out_valid_reg;
    out_item_t       out_item_reg;

    logic            in_accept;
    logic            out_load;
    logic            cfg_write;
    logic [47:0]     alu_a;
    logic [31:0]     alu_b;
    logic            alu_sub;
    logic [48:0]     alu_sum;
    logic            fit_now;
    logic            oversize;
    logic            admit_ok;
    logic            evict_limit_hit;
    logic [47:0]     drop_bytes_sat;
    logic [31:0]     drop_rec_inc;
    logic [CW-1:0]   mem_lidx;
    logic [AW-1:0]   mem_addr;
    logic [AW-1:0]   head_inc;
    logic            mem_rd_en;
    logic            mem_wr_en;
    entry_t          mem_wr_data;
    entry_t          mem_rd_data;

    // Map a position counted from the oldest entry to a store address
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lidx);
        logic [CW:0] s;
        begin
            s = (CW+1)'(head) + (CW+1)'(lidx);
            if (s >= (CW+1)'(DEPTH))
            begin
                s = s - (CW+1)'(DEPTH);
            end
            return s[AW-1:0];
        end
    endfunction

    // Handshakes
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == CFG_BYTE_CAP);
    assign prdata    = (paddr[2] == CFG_BYTE_CAP) ? byte_cap_reg : 32'd0;

    // Shared add/subtract unit and the decisions built on it
    assign alu_sum = alu_sub ? ({1'b0, alu_a} - {17'd0, alu_b})
                             : ({1'b0, alu_a} + {17'd0, alu_b});
    assign fit_now = (count_reg < CW'(MAX_JOBS)) && (alu_sum <= {17'd0, byte_cap_reg});
    assign oversize = req_reg.job_droppable && (req_reg.job_bytes > byte_cap_reg);
    assign admit_ok = !((!fits_reg && req_reg.job_droppable) ||
                        (count_reg >= CW'(DEPTH)));
    assign evict_limit_hit = (evicted_reg == EW'(MAX_JOBS + 1));
    assign drop_bytes_sat = (alu_sum >= {1'b0, DROP_BYTES_MAX}) ? DROP_BYTES_MAX
                                                                : alu_sum[47:0];
    assign drop_rec_inc = (drop_rec_reg == DROP_RECORDS_MAX) ? drop_rec_reg
                                                             : drop_rec_reg + 32'd1;
    assign mem_addr = phys(head_reg, mem_lidx);
    assign head_inc = phys(head_reg, CW'(1));

    bcdq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (req_reg.cmd)
                    CMD_PUSH:
                    begin
                        if (oversize)
                        begin
                            state_next = ST_DROP_NEW;
                        end
                        else if (stop_reg)
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_FIT;
                        end
                    end
                    CMD_POP:
                    begin
                        state_next = (count_reg == '0) ? ST_DONE : ST_POP_RD;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_FIT:
            begin
                state_next = (fit_now || evict_limit_hit) ? ST_DECIDE : ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                state_next = (scan_pos_reg < count_reg) ? ST_SCAN_CHK : ST_DECIDE;
            end
            ST_SCAN_CHK:
            begin
                state_next = mem_rd_data.drop_ok ? ST_EVICT_NOTE : ST_SCAN_RD;
            end
            ST_EVICT_NOTE:
            begin
                state_next = ST_EVICT_SUB;
            end
            ST_EVICT_SUB:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_SHIFT_RD:
            begin
                state_next = (shift_pos_reg == '0) ? ST_FIT : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_DECIDE:
            begin
                state_next = admit_ok ? ST_DONE : ST_DROP_NEW;
            end
            ST_DROP_NEW:
            begin
                state_next = ST_DONE;
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_FIN;
            end
            ST_POP_FIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Store access and adder operands per state
    always_comb
    begin
        mem_lidx    = '0;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_data = mem_rd_data;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        unique case (state_reg)
            ST_FIT:
            begin
                alu_a = {8'd0, byte_total_reg};
                alu_b = req_reg.job_bytes;
            end
            ST_SCAN_RD:
            begin
                mem_lidx  = scan_pos_reg;
                mem_rd_en = (scan_pos_reg < count_reg);
            end
            ST_EVICT_NOTE:
            begin
                alu_a = drop_bytes_reg;
                alu_b = mem_rd_data.bytes;
            end
            ST_EVICT_SUB:
            begin
                alu_a   = {8'd0, byte_total_reg};
                alu_b   = mem_rd_data.bytes;
                alu_sub = 1'b1;
            end
            ST_SHIFT_RD:
            begin
                mem_lidx  = shift_pos_reg - CW'(1);
                mem_rd_en = (shift_pos_reg != '0);
            end
            ST_SHIFT_WR:
            begin
                mem_lidx  = shift_pos_reg;
                mem_wr_en = 1'b1;
            end
            ST_DECIDE:
            begin
                alu_a       = {8'd0, byte_total_reg};
                alu_b       = req_reg.job_bytes;
                mem_lidx    = count_reg;
                mem_wr_en   = admit_ok;
                mem_wr_data = '{tag: req_reg.job_tag, bytes: req_reg.job_bytes,
                                drop_ok: req_reg.job_droppable};
            end
            ST_DROP_NEW:
            begin
                alu_a = drop_bytes_reg;
                alu_b = req_reg.job_bytes;
            end
            ST_POP_RD:
            begin
                mem_lidx  = '0;
                mem_rd_en = 1'b1;
            end
            ST_POP_FIN:
            begin
                alu_a   = {8'd0, byte_total_reg};
                alu_b   = mem_rd_data.bytes;
                alu_sub = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control state and queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            byte_cap_reg   <= BYTE_CAP_RESET;
            head_reg       <= '0;
            count_reg      <= '0;
            byte_total_reg <= '0;
            drop_rec_reg   <= '0;
            drop_bytes_reg <= '0;
            stop_reg       <= 1'b0;
            overflow_reg   <= 1'b0;
            evicted_reg    <= '0;
            scan_pos_reg   <= '0;
            shift_pos_reg  <= '0;
            fits_reg       <= 1'b0;
            status_reg     <= STATUS_ACCEPTED;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                byte_cap_reg <= pwdata;
            end

            // Hold the result until the receiver takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        evicted_reg  <= '0;
                        scan_pos_reg <= '0;
                    end
                end
                ST_DISPATCH:
                begin
                    unique case (req_reg.cmd)
                        CMD_PUSH:
                        begin
                            if (stop_reg)
                            begin
                                status_reg <= STATUS_STOPPED;
                            end
                        end
                        CMD_POP:
                        begin
                            status_reg <= STATUS_EMPTY;
                        end
                        CMD_STOP:
                        begin
                            stop_reg   <= 1'b1;
                            status_reg <= STATUS_ACCEPTED;
                        end
                        CMD_CLEAR:
                        begin
                            drop_rec_reg   <= '0;
                            drop_bytes_reg <= '0;
                            overflow_reg   <= 1'b0;
                            status_reg     <= STATUS_ACCEPTED;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_FIT:
                begin
                    fits_reg <= fit_now;
                end
                ST_SCAN_CHK:
                begin
                    // Entries ahead of the victim stay non-droppable: keep scan position
                    if (mem_rd_data.drop_ok)
                    begin
                        shift_pos_reg <= scan_pos_reg;
                    end
                    else
                    begin
                        scan_pos_reg <= scan_pos_reg + CW'(1);
                    end
                end
                ST_EVICT_NOTE:
                begin
                    drop_rec_reg   <= drop_rec_inc;
                    drop_bytes_reg <= drop_bytes_sat;
                    overflow_reg   <= 1'b1;
                end
                ST_EVICT_SUB:
                begin
                    byte_total_reg <= alu_sum[39:0];
                end
                ST_SHIFT_RD:
                begin
                    // Victim slot now holds its predecessor: drop the oldest slot
                    if (shift_pos_reg == '0)
                    begin
                        head_reg    <= head_inc;
                        count_reg   <= count_reg - CW'(1);
                        evicted_reg <= evicted_reg + EW'(1);
                    end
                end
                ST_SHIFT_WR:
                begin
                    shift_pos_reg <= shift_pos_reg - CW'(1);
                end
                ST_DECIDE:
                begin
                    if (admit_ok)
                    begin
                        count_reg      <= count_reg + CW'(1);
                        byte_total_reg <= alu_sum[39:0];
                        status_reg     <= (evicted_reg != '0) ? STATUS_EVICTED
                                                              : STATUS_ACCEPTED;
                    end
                end
                ST_DROP_NEW:
                begin
                    drop_rec_reg   <= drop_rec_inc;
                    drop_bytes_reg <= drop_bytes_sat;
                    overflow_reg   <= 1'b1;
                    status_reg     <= STATUS_REJECTED;
                end
                ST_POP_FIN:
                begin
                    head_reg       <= head_inc;
                    count_reg      <= count_reg - CW'(1);
                    byte_total_reg <= alu_sum[39:0];
                    status_reg     <= STATUS_POPPED;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers: latched command, popped entry, result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg       <= in_item;
            pop_entry_reg <= '0;
        end
        if (state_reg == ST_POP_FIN)
        begin
            pop_entry_reg <= mem_rd_data;
        end
        if (out_load)
        begin
            out_item_reg.status        <= status_reg;
            out_item_reg.evicted_count <= 5'(evicted_reg);
            out_item_reg.out_tag       <= pop_entry_reg.tag;
            out_item_reg.out_bytes     <= pop_entry_reg.bytes;
            out_item_reg.out_droppable <= pop_entry_reg.drop_ok;
            out_item_reg.jobs_held     <= 5'(count_reg);
            out_item_reg.bytes_held    <= byte_total_reg;
            out_item_reg.lost_records  <= drop_rec_reg;
            out_item_reg.lost_bytes    <= drop_bytes_reg;
            out_item_reg.overflow_seen <= overflow_reg;
        end
    end

endmodule

[sv/bcdq_store.sv]
module bcdq_store
    import bcdq_pkg::*;
#(
    parameter int DEPTH = 20,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/bcdq_checker.sv]
module bcdq_checker
    import bcdq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    // One command at a time: the block is busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("command taken while previous one runs");

    // Pop fields are zero unless a job was popped
    a_pop_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status != STATUS_POPPED) |->
            (out_item.out_tag == 16'd0) && (out_item.out_bytes == 32'd0) &&
            !out_item.out_droppable)
        else $error("pop fields set on non-pop result");

    // Empty answer reports an empty queue
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == STATUS_EMPTY) |->
            (out_item.jobs_held == 5'd0) && (out_item.bytes_held == 40'd0))
        else $error("empty status with queued jobs");

    // Evictions come only with an eviction or a rejection, and mark overflow
    a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.evicted_count != 5'd0) |->
            ((out_item.status == STATUS_EVICTED) ||
             (out_item.status == STATUS_REJECTED)) && out_item.overflow_seen)
        else $error("evictions reported with wrong status");

endmodule

bind byte_capped_drop_oldest_queue_top bcdq_checker u_bcdq_checker (.*);

[test/byte_capped_drop_oldest_queue_top_tb.sv]
module byte_capped_drop_oldest_queue_top_tb;
    import bcdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_JOBS    = 16;
    localparam int STORE_DEPTH = 20;
    localparam int LONGEST_CMD = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Commands waiting to be sent, and replies the block still owes
    in_item_t    pending_cmds[$];
    out_item_t   owed_replies[$];
    int          queued_count = 0;
    int          accepted_count = 0;
    int          fail_count = 0;
    int          gap_pct = 17;
    int          stall_pct = 17;
    int          status_hits[8];
    int          cap_settings = 1;

    // Mirror of the job queue and its counters
    logic [15:0]     jq_tag[STORE_DEPTH];
    logic [31:0]     jq_bytes[STORE_DEPTH];
    logic            jq_drop_ok[STORE_DEPTH];
    int unsigned     jq_count = 0;
    longint unsigned jq_byte_sum = 0;
    longint unsigned loss_records = 0;
    longint unsigned loss_bytes = 0;
    longint unsigned cap_now = BYTE_CAP_RESET;
    bit              stop_seen = 1'b0;
    bit              loss_flag = 1'b0;

    byte_capped_drop_oldest_queue_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Count a rejected or evicted job, saturating both totals
    function automatic void note_loss(longint unsigned nbytes);
        if (loss_records < longint'(DROP_RECORDS_MAX))
            loss_records++;
        if (nbytes >= longint'(DROP_BYTES_MAX) - loss_bytes)
            loss_bytes = DROP_BYTES_MAX;
        else
            loss_bytes += nbytes;
        loss_flag = 1'b1;
    endfunction

    function automatic bit has_room(longint unsigned nbytes);
        return jq_count < MAX_JOBS && jq_byte_sum + nbytes <= cap_now;
    endfunction

    // Remove one entry and close the gap behind it
    function automatic void remove_entry(int unsigned pos);
        int unsigned i;
        jq_byte_sum -= jq_bytes[pos];
        for (i = pos; i + 1 < jq_count; i++)
        begin
            jq_tag[i]     = jq_tag[i + 1];
            jq_bytes[i]   = jq_bytes[i + 1];
            jq_drop_ok[i] = jq_drop_ok[i + 1];
        end
        jq_count--;
    endfunction

    // Advance the queue mirror by one command and build the reply it owes
    function automatic out_item_t apply_cmd(in_item_t c);
        out_item_t       r;
        longint unsigned nb;
        int unsigned     tries;
        int unsigned     k;
        int unsigned     evicted;
        bit              refuse;
        r = '0;
        nb = c.job_bytes;
        evicted = 0;
        case (c.cmd)
            CMD_PUSH:
            begin
                if (c.job_droppable && nb > cap_now)
                begin
                    note_loss(nb);
                    r.status = STATUS_REJECTED;
                end
                else if (stop_seen)
                    r.status = STATUS_STOPPED;
                else
                begin
                    // Evict oldest droppable entries until the job fits
                    for (tries = 0; tries < MAX_JOBS + 1; tries++)
                    begin
                        if (has_room(nb))
                            break;
                        k = 0;
                        while (k < jq_count && !jq_drop_ok[k])
                            k++;
                        if (k >= jq_count)
                            break;
                        note_loss(jq_bytes[k]);
                        remove_entry(k);
                        evicted++;
                    end
                    refuse = (!has_room(nb) && c.job_droppable) || jq_count >= STORE_DEPTH;
                    if (refuse)
                    begin
                        note_loss(nb);
                        r.status = STATUS_REJECTED;
                    end
                    else
                    begin
                        jq_tag[jq_count]     = c.job_tag;
                        jq_bytes[jq_count]   = c.job_bytes;
                        jq_drop_ok[jq_count] = c.job_droppable;
                        jq_count++;
                        jq_byte_sum = (jq_byte_sum + nb) & 64'hFF_FFFF_FFFF;
                        r.status = (evicted != 0) ? STATUS_EVICTED : STATUS_ACCEPTED;
                    end
                end
            end
            CMD_POP:
            begin
                if (jq_count == 0)
                    r.status = STATUS_EMPTY;
                else
                begin
                    r.out_tag       = jq_tag[0];
                    r.out_bytes     = jq_bytes[0];
                    r.out_droppable = jq_drop_ok[0];
                    remove_entry(0);
                    r.status = STATUS_POPPED;
                end
            end
            CMD_STOP:
            begin
                stop_seen = 1'b1;
                r.status = STATUS_ACCEPTED;
            end
            default:
            begin
                loss_records = 0;
                loss_bytes = 0;
                loss_flag = 1'b0;
                r.status = STATUS_ACCEPTED;
            end
        endcase
        r.evicted_count = evicted[4:0];
        r.jobs_held     = jq_count[4:0];
        r.bytes_held    = jq_byte_sum[39:0];
        r.lost_records  = loss_records[31:0];
        r.lost_bytes    = loss_bytes[47:0];
        r.overflow_seen = loss_flag;
        status_hits[r.status]++;
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_reply(out_item_t want, out_item_t got);
        check_field("status", want.status, got.status);
        check_field("evicted_count", want.evicted_count, got.evicted_count);
        check_field("out_tag", want.out_tag, got.out_tag);
        check_field("out_bytes", want.out_bytes, got.out_bytes);
        check_field("out_droppable", want.out_droppable, got.out_droppable);
        check_field("jobs_held", want.jobs_held, got.jobs_held);
        check_field("bytes_held", want.bytes_held, got.bytes_held);
        check_field("lost_records", want.lost_records, got.lost_records);
        check_field("lost_bytes", want.lost_bytes, got.lost_bytes);
        check_field("overflow_seen", want.overflow_seen, got.overflow_seen);
    endfunction

    // Drive the command channel; record every accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                owed_replies.insert(owed_replies.size(), apply_cmd(in_item));
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    in_item  <= pending_cmds[0];
                    in_valid <= 1'b1;
                    pending_cmds.delete(0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Check each reply transaction against the oldest owed reply
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("reply with status %0d arrived with none owed", out_item.status);
                    fail_count++;
                end
                else
                begin
                    check_reply(owed_replies[0], out_item);
                    owed_replies.delete(0);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic add_cmd(cmd_t c, logic [31:0] nbytes, logic drop_ok, logic [15:0] tag);
        in_item_t it;
        it.cmd = c;
        it.job_bytes = nbytes;
        it.job_droppable = drop_ok;
        it.job_tag = tag;
        pending_cmds.insert(pending_cmds.size(), it);
        queued_count++;
    endtask

    // Job sizes scaled to the current cap, with edges and full-range values mixed in
    function automatic logic [31:0] pick_bytes();
        logic [31:0] cap32;
        cap32 = cap_now[31:0];
        case ($urandom_range(9))
            0: return '0;
            1: return $urandom;
            2: return cap32;
            3: return cap32 + 32'd1;
            4, 5: return $urandom_range(cap32);
            default: return $urandom_range(cap32 / 6);
        endcase
    endfunction

    task automatic queue_random(int n, int push_pct, bit with_stop);
        int   i;
        int   roll;
        cmd_t c;
        for (i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < push_pct)
                c = CMD_PUSH;
            else if (roll < 94)
                c = CMD_POP;
            else if (with_stop && roll < 96)
                c = CMD_STOP;
            else
                c = CMD_CLEAR;
            add_cmd(c, pick_bytes(), $urandom_range(99) < 75, 16'($urandom));
        end
    endtask

    // Hold off until every sent command has been answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (accepted_count != queued_count || owed_replies.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == CFG_BYTE_CAP)
        begin
            cap_now = data;
            cap_settings++;
        end
    endtask

    task automatic apb_check_cap();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        check_field("byte_cap", cap_now, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] phase_caps[6];
        int          phase_push[6];
        int          p;
        int          i;

        phase_caps = '{32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, BYTE_CAP_RESET};
        phase_push = '{60, 55, 65, 62, 50, 58};
        phase_caps[3] = $urandom_range(60000, 200);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        apb_check_cap();

        // Default cap: empty pop, exact fit, oversized, a non-droppable job admitted past the cap after evictions
        add_cmd(CMD_POP, 32'h0, 1'b1, 16'h0);
        add_cmd(CMD_PUSH, BYTE_CAP_RESET, 1'b1, 16'hFFFF);
        add_cmd(CMD_PUSH, BYTE_CAP_RESET + 32'd1, 1'b1, 16'h1234);
        add_cmd(CMD_PUSH, 32'h0, 1'b1, 16'h0000);
        add_cmd(CMD_PUSH, 32'hFFFF_FFFF, 1'b0, 16'hAAAA);
        add_cmd(CMD_PUSH, 32'h1, 1'b1, 16'h5555);
        add_cmd(CMD_CLEAR, 32'h0, 1'b0, 16'h0);
        add_cmd(CMD_POP, 32'h0, 1'b0, 16'h0);
        wait_drained();

        // Small cap: hit the job limit, then push barriers and a small job that each evict to fit
        apb_write(3'd0, 32'd100);
        apb_write(3'd4, 32'h1234_5678);
        apb_check_cap();
        for (i = 0; i < MAX_JOBS; i++)
            add_cmd(CMD_PUSH, 32'd5, 1'b1, 16'(i));
        for (i = 0; i < STORE_DEPTH - MAX_JOBS + 1; i++)
            add_cmd(CMD_PUSH, 32'd7, 1'b0, 16'(16'h8000 + i));
        add_cmd(CMD_PUSH, 32'd1, 1'b1, 16'h7777);
        wait_drained();

        // Random phases over a spread of caps; one runs with no idling at all
        for (p = 0; p < 6; p++)
        begin
            apb_write(3'd0, phase_caps[p]);
            gap_pct   = (p == 2) ? 0 : 17;
            stall_pct = (p == 2) ? 0 : 17;
            queue_random(100, phase_push[p], 1'b0);
            wait_drained();
        end
        gap_pct   = 17;
        stall_pct = 17;

        // Stop: pushes are refused, oversized ones still rejected, pops drain
        apb_write(3'd0, 32'd5000);
        queue_random(60, 65, 1'b0);
        add_cmd(CMD_STOP, 32'h0, 1'b0, 16'h0);
        add_cmd(CMD_PUSH, 32'd6000, 1'b1, 16'h0101);
        add_cmd(CMD_PUSH, 32'd10, 1'b1, 16'h0202);
        add_cmd(CMD_PUSH, 32'd10, 1'b0, 16'h0303);
        queue_random(40, 50, 1'b1);
        for (i = 0; i < STORE_DEPTH + 2; i++)
            add_cmd(CMD_POP, $urandom, 1'b0, 16'($urandom));
        add_cmd(CMD_CLEAR, 32'h0, 1'b0, 16'h0);
        wait_drained();

        repeat (LONGEST_CMD) @(posedge clk);

        $display("Sent %0d commands over %0d byte caps: %0d accepted, %0d after eviction, %0d rejected",
                 accepted_count, cap_settings, status_hits[STATUS_ACCEPTED],
                 status_hits[STATUS_EVICTED], status_hits[STATUS_REJECTED]);
        $display("Refused after stop %0d, pops on empty queue %0d, jobs popped %0d",
                 status_hits[STATUS_STOPPED], status_hits[STATUS_EMPTY],
                 status_hits[STATUS_POPPED]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Give up if the block hangs
    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
